### hw/rtl/ils_pkg.sv
package ils_pkg;

    // List size and derived widths.
    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int POS_W      = 16;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;
    localparam int LEN_W      = 9;
    localparam int CMP_W      = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

    // Read tree shape: groups of cells reduced in the first stage.
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W  = ((CMD_W + POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_W + STAT_W + LEN_W + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_AT   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } cell_ctrl_t;

endpackage

### hw/rtl/ils_cell.sv
module ils_cell
    import ils_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  cell_index,
    input  logic [IDX_W-1:0]  rd_index,
    input  logic [DATA_W-1:0] left_in,
    input  logic [DATA_W-1:0] right_in,
    output logic [DATA_W-1:0] value_out,
    output logic [DATA_W-1:0] read_out
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    // Insert opens a gap at the index, delete closes the gap there.
    always_comb begin
        value_next = value_reg;
        if (ctrl.ins) begin
            if (cell_index > ctrl.idx) begin
                value_next = left_in;
            end else if (cell_index == ctrl.idx) begin
                value_next = ctrl.data;
            end
        end else if (ctrl.del) begin
            if (cell_index >= ctrl.idx) begin
                value_next = right_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;

    // Only the addressed cell puts its value on the read tree.
    assign read_out = (cell_index == rd_index) ? value_reg : '0;

endmodule

### hw/rtl/ils_read_tree.sv
module ils_read_tree
    import ils_pkg::*;
(
    input  logic              aclk,
    input  logic [DATA_W-1:0] cell_rd [CAPACITY],
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] group_next [NUM_GROUPS];
    logic [DATA_W-1:0] group_reg  [NUM_GROUPS];
    logic [DATA_W-1:0] final_next;
    logic [DATA_W-1:0] final_reg;

    // First stage: OR together the masked values of each group of cells.
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < CAPACITY) begin
                    group_next[g] = group_next[g] | cell_rd[g * GROUP_SIZE + k];
                end
            end
        end
    end

    // Second stage: OR the group results.
    always_comb begin
        final_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            final_next = final_next | group_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
        final_reg <= final_next;
    end

    assign rd_data = final_reg;

endmodule

### hw/rtl/indexed_list_store.sv
// Ordered list of up to CAPACITY signed 32-bit values, held in a chain of
// entry cells. Each request carries a command (get, insert at head, insert at
// tail, insert before an index, delete at an index), a position and a value,
// and produces exactly one result with the read value, a status and the list
// length after the command. Inserts and deletes shift every later cell by one
// place, all cells updating on the same clock edge. One request is handled at a
// time: an insert, delete or invalid command passes from acceptance through an
// execute state and a done state before the next acceptance, and a valid get
// also passes through the two registered stages of the OR tree that collects
// the addressed cell. A finished result waits in the output register while the
// next request is accepted. The list is empty after reset.
module indexed_list_store
    import ils_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cmd, position, value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_value, status, length
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [DATA_W-1:0] rdv_reg, rdv_next;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_rdv_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic [LEN_W-1:0]  m_len_reg;

    logic              s_accept;
    logic              out_free;
    logic              pos_neg;
    logic [CMP_W-1:0]  pos_mag;
    logic [CMP_W-1:0]  cnt_ext;
    logic              full;
    logic              get_ok;
    logic              ins_ok;
    logic              del_ok;
    logic [IDX_W-1:0]  ins_idx;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] cell_rd  [CAPACITY];
    logic [DATA_W-1:0] tree_data;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Command decode against the length held before the command.
    assign pos_neg = pos_reg[POS_W-1];
    assign pos_mag = CMP_W'(pos_reg[POS_W-2:0]);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        get_ok    = 1'b0;
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
        ins_idx   = pos_reg[IDX_W-1:0];
        stat_next = STAT_DONE;
        case (cmd_reg)
            CMD_GET: begin
                if (pos_neg || pos_mag >= cnt_ext) begin
                    stat_next = STAT_INVALID;
                end else begin
                    get_ok = 1'b1;
                end
            end
            CMD_INS_HEAD: begin
                ins_idx = '0;
                if (full) begin
                    stat_next = STAT_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            CMD_INS_TAIL: begin
                ins_idx = count_reg[IDX_W-1:0];
                if (full) begin
                    stat_next = STAT_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            CMD_INS_AT: begin
                if (pos_neg || pos_mag > cnt_ext) begin
                    stat_next = STAT_INVALID;
                end else if (full) begin
                    stat_next = STAT_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            CMD_DEL_AT: begin
                if (pos_neg || pos_mag >= cnt_ext) begin
                    stat_next = STAT_INVALID;
                end else begin
                    del_ok = 1'b1;
                end
            end
            default: begin
                stat_next = STAT_INVALID;
            end
        endcase
    end

    // Shift control for the whole chain, active for one cycle.
    always_comb begin
        ctrl.ins  = (state_reg == S_EXEC) && ins_ok;
        ctrl.del  = (state_reg == S_EXEC) && del_ok;
        ctrl.idx  = ins_idx;
        ctrl.data = val_reg;
    end

    // Chain of entry cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;
        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[i+1];
        end
        ils_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(i)),
            .rd_index   (pos_reg[IDX_W-1:0]),
            .left_in    (left_val),
            .right_in   (right_val),
            .value_out  (cell_val[i]),
            .read_out   (cell_rd[i])
        );
    end

    ils_read_tree u_read_tree (
        .aclk    (aclk),
        .cell_rd (cell_rd),
        .rd_data (tree_data)
    );

    // Sequencer and length.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rdv_next   = rdv_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ins_ok) begin
                    count_next = count_reg + CNT_W'(1);
                end else if (del_ok) begin
                    count_next = count_reg - CNT_W'(1);
                end
                if (get_ok) begin
                    state_next = S_RD1;
                end else begin
                    state_next = S_DONE;
                end
                if (cmd_reg == CMD_GET) begin
                    rdv_next = '1;
                end else begin
                    rdv_next = '0;
                end
            end
            S_RD1: begin
                state_next = S_RD2;
            end
            S_RD2: begin
                rdv_next   = tree_data;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Request and working payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            pos_reg <= s_tdata[CMD_W+POS_W-1:CMD_W];
            val_reg <= s_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];
        end
        if (state_reg == S_EXEC) begin
            stat_reg <= stat_next;
        end
        rdv_reg <= rdv_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_rdv_reg  <= rdv_reg;
            m_stat_reg <= stat_reg;
            m_len_reg  <= LEN_W'(count_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_len_reg, m_stat_reg, m_rdv_reg});

`ifndef ASSERT_OFF
    // The length never exceeds the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    // The length moves by at most one entry per clock.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg))
              || (count_reg == $past(count_reg) + CNT_W'(1))
              || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("list length jumped");

    // An accepted request always starts execution next cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

    // A finished command with a free output slot shows its result next cycle.
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> m_tvalid_reg)
        else $error("result not presented");
`endif

endmodule

### test/tb.sv
module tb;
    import ils_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 1325;

    // One expected or observed result, split into its fields.
    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    typedef enum {MODE_GROW, MODE_MIX, MODE_SHRINK} traffic_mode_t;

    // Scoreboard: keeps its own copy of the list and the results still owed.
    class list_scoreboard;
        logic [DATA_W-1:0] entries [CAPACITY];
        int unsigned       list_len;
        list_result_t      pending [$];
        int unsigned       errors;

        function new();
            list_len = 0;
            errors   = 0;
        endfunction

        // Shift the entries at and above a slot up by one and fill the slot.
        function void open_slot(int unsigned at, logic [DATA_W-1:0] val);
            for (int unsigned i = list_len; i > at; i--) begin
                entries[i] = entries[i - 1];
            end
            entries[at] = val;
            list_len++;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] val);
            list_result_t r;
            logic         neg;
            int unsigned  idx;
            neg          = pos[POS_W-1];
            idx          = 32'(pos);
            r.read_value = '0;
            r.status     = STAT_DONE;
            case (cmd)
                CMD_GET: begin
                    if (neg || idx >= list_len) begin
                        r.read_value = '1;
                        r.status     = STAT_INVALID;
                    end else begin
                        r.read_value = entries[idx];
                    end
                end
                CMD_INS_HEAD: begin
                    if (list_len >= CAPACITY) r.status = STAT_FULL;
                    else open_slot(0, val);
                end
                CMD_INS_TAIL: begin
                    if (list_len >= CAPACITY) r.status = STAT_FULL;
                    else open_slot(list_len, val);
                end
                CMD_INS_AT: begin
                    // The index is checked before the fill level.
                    if (neg || idx > list_len) r.status = STAT_INVALID;
                    else if (list_len >= CAPACITY) r.status = STAT_FULL;
                    else open_slot(idx, val);
                end
                CMD_DEL_AT: begin
                    if (neg || idx >= list_len) begin
                        r.status = STAT_INVALID;
                    end else begin
                        for (int unsigned i = idx; i + 1 < list_len; i++) begin
                            entries[i] = entries[i + 1];
                        end
                        list_len--;
                    end
                end
                default: begin
                    r.status = STAT_INVALID;
                end
            endcase
            r.length = LEN_W'(list_len);
            pending.push_back(r);
        endfunction

        function void report(string field, logic signed [DATA_W-1:0] want,
                             logic signed [DATA_W-1:0] got);
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        // Compare one delivered result with the oldest one owed.
        function void check_result(logic [M_TDATA_W-1:0] d);
            list_result_t got;
            list_result_t want;
            got.read_value = d[DATA_W-1:0];
            got.status     = d[DATA_W +: STAT_W];
            got.length     = d[DATA_W + STAT_W +: LEN_W];
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with none expected", $time, d);
            end else begin
                want = pending.pop_front();
                if (got.read_value !== want.read_value) begin
                    report("read_value", want.read_value, got.read_value);
                end
                if (got.status !== want.status) begin
                    report("status", DATA_W'(want.status), DATA_W'(got.status));
                end
                if (got.length !== want.length) begin
                    report("length", DATA_W'(want.length), DATA_W'(got.length));
                end
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    list_scoreboard sb = new();
    bit             steady = 1'b0;
    int unsigned    cycle_count = 0;

    indexed_list_store u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: check each delivered result and stall at random.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
        m_tready <= steady || ($urandom_range(99) >= 38);
    end

    // Offer one request, with random idle cycles in front, and wait for acceptance.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val);
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, pos, cmd});
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, pos, val);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        traffic_mode_t     mode;
        traffic_mode_t     after_mix;
        int unsigned       mode_count;
        int unsigned       len;
        int unsigned       top;
        int unsigned       roll;
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests: empty list, index edges and odd commands.
        send_request(CMD_GET,      16'd0,    32'd0);
        send_request(CMD_DEL_AT,   16'd0,    32'd0);
        send_request(CMD_INS_AT,   16'd1,    32'd5);
        send_request(CMD_INS_AT,   16'd0,    32'h7FFF_FFFF);
        send_request(CMD_INS_HEAD, 16'd0,    32'h8000_0000);
        send_request(CMD_INS_TAIL, 16'd0,    32'hFFFF_FFFF);
        send_request(CMD_INS_AT,   16'd3,    32'd0);
        send_request(CMD_INS_AT,   16'hFFFF, 32'd11);
        send_request(CMD_INS_AT,   16'h8000, 32'd12);
        send_request(CMD_INS_AT,   16'h7FFF, 32'd13);
        send_request(CMD_INS_AT,   16'd1,    32'h1234_5678);
        send_request(CMD_GET,      16'd0,    32'd0);
        send_request(CMD_GET,      16'd1,    32'd0);
        send_request(CMD_GET,      16'd4,    32'd0);
        send_request(CMD_GET,      16'd5,    32'd0);
        send_request(CMD_GET,      16'hFFFF, 32'd0);
        send_request(CMD_GET,      16'h7FFF, 32'd0);
        send_request(3'd5,         16'd0,    32'd99);
        send_request(3'd6,         16'hFFFF, 32'hFFFF_FFFF);
        send_request(3'd7,         16'd2,    32'd1);
        send_request(CMD_DEL_AT,   16'h8000, 32'd0);
        send_request(CMD_DEL_AT,   16'd5,    32'd0);
        send_request(CMD_DEL_AT,   16'd4,    32'd0);
        send_request(CMD_DEL_AT,   16'd0,    32'd0);
        send_request(CMD_DEL_AT,   16'd1,    32'd0);

        // Random traffic: fill to capacity, mix, drain to empty, and again.
        mode       = MODE_GROW;
        after_mix  = MODE_SHRINK;
        mode_count = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady = (n >= 700 && n < 950);
            if (n == 500) begin
                wait_for_results();
            end
            len  = sb.list_len;
            roll = $urandom_range(99);
            case (mode)
                MODE_GROW: begin
                    cmd = (roll < 30) ? CMD_INS_HEAD : (roll < 60) ? CMD_INS_TAIL :
                          (roll < 85) ? CMD_INS_AT : (roll < 93) ? CMD_GET : CMD_DEL_AT;
                end
                MODE_SHRINK: begin
                    cmd = (roll < 75) ? CMD_DEL_AT : (roll < 87) ? CMD_GET :
                          (roll < 91) ? CMD_INS_HEAD : (roll < 95) ? CMD_INS_TAIL :
                          CMD_INS_AT;
                end
                default: begin
                    cmd = (roll < 20) ? CMD_GET : (roll < 35) ? CMD_INS_HEAD :
                          (roll < 50) ? CMD_INS_TAIL : (roll < 70) ? CMD_INS_AT :
                          CMD_DEL_AT;
                end
            endcase
            if ($urandom_range(99) < 2) begin
                cmd = CMD_W'($urandom_range(7, 5));
            end

            // Mostly valid indices, some just past the end, some arbitrary or negative.
            top  = (cmd == CMD_INS_AT) ? len : ((len == 0) ? 0 : len - 1);
            roll = $urandom_range(99);
            if (roll < 78) begin
                pos = POS_W'($urandom_range(top));
            end else if (roll < 88) begin
                pos = POS_W'(top + 1);
            end else if (roll < 94) begin
                pos = POS_W'($urandom);
            end else begin
                pos = POS_W'($urandom);
                pos[POS_W-1] = 1'b1;
            end

            roll = $urandom_range(99);
            if (roll < 3) val = 32'h8000_0000;
            else if (roll < 6) val = 32'h7FFF_FFFF;
            else if (roll < 8) val = '1;
            else if (roll < 10) val = '0;
            else val = $urandom;

            send_request(cmd, pos, val);

            // Move between phases once the list has sat at its limit for a while, or after a run of mixed requests.
            case (mode)
                MODE_GROW: begin
                    if (len == CAPACITY) mode_count++;
                    if (mode_count >= 12) begin
                        mode       = MODE_MIX;
                        after_mix  = MODE_SHRINK;
                        mode_count = 0;
                    end
                end
                MODE_SHRINK: begin
                    if (len == 0) mode_count++;
                    if (mode_count >= 8) begin
                        mode       = MODE_MIX;
                        after_mix  = MODE_GROW;
                        mode_count = 0;
                    end
                end
                default: begin
                    mode_count++;
                    if (mode_count >= 120) begin
                        mode       = after_mix;
                        mode_count = 0;
                    end
                end
            endcase
        end
        steady = 1'b0;

        // Let every owed result arrive, then a little longer for strays.
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ils_pkg.sv
hw/rtl/ils_cell.sv
hw/rtl/ils_read_tree.sv
hw/rtl/indexed_list_store.sv
test/tb.sv
